// ----- rtl/sacl_pkg.sv -----
// Shared types and constants for the set-associative LRU cache lookup block.
`timescale 1ns / 1ps

package sacl_pkg;

   localparam int ADDR_PORT_W  = 64;
   localparam int TOTAL_W      = 32;
   localparam int SET_BITS_W   = 3;
   localparam int WAYS_W       = 4;
   localparam int BLOCK_BITS_W = 6;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BITS = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // request taken: split address, read the set
      logic latch;      // register compare results of the set just read
      logic scan_step;  // examine one way for the LRU victim
      logic commit;     // write the set back and load the result register
      logic clear_wr;   // clear valid bits of one set after reset
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;
      logic free_any;
      logic scan_last;
      logic clear_last;
   } status_type;

endpackage

// ----- rtl/sacl_ctrl.sv -----
// Controller state machine: clearing pass, request sequencing, result handshake.
`timescale 1ns / 1ps

module sacl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sacl_pkg::status_type status,
   output sacl_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_WRITE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.latch     = (state_ff == ST_LOOKUP);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.commit    = (state_ff == ST_WRITE) && out_free;
      cmd.clear_wr  = (state_ff == ST_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_LOOKUP;
            end
            ST_LOOKUP: begin
               // no hit and no invalid way: walk the ways for the LRU victim
               if (status.hit || status.free_any) state_ff <= ST_WRITE;
               else state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (status.scan_last) state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

endmodule

// ----- rtl/sacl_dpath.sv -----
// Datapath: config registers, set memories, tag compare, victim scan, totals.
`timescale 1ns / 1ps

module sacl_dpath #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64,
   parameter int STAMP_WIDTH  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sacl_pkg::cmd_type                     cmd,
   output sacl_pkg::status_type                  status,
   input  logic [sacl_pkg::ADDR_PORT_W-1:0]      req_address,
   input  logic                                  csr_wr,
   input  logic [sacl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                  rsp_hit,
   output logic                                  rsp_miss,
   output logic                                  rsp_eviction,
   output logic [sacl_pkg::TOTAL_W-1:0]          rsp_hit_total,
   output logic [sacl_pkg::TOTAL_W-1:0]          rsp_miss_total,
   output logic [sacl_pkg::TOTAL_W-1:0]          rsp_eviction_total
);

   localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS  = 1 << MAX_SET_BITS;
   localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SHIFT_W   = $clog2(MAX_SET_BITS + 64);
   localparam logic [3:0] SMAX = 4'(MAX_SET_BITS);
   localparam logic [5:0] WMAX = 6'(MAX_WAYS);
   localparam logic [SET_IDX_W-1:0] LAST_SET = SET_IDX_W'(NUM_SETS - 1);

   typedef logic [MAX_WAYS-1:0]                  valid_row_type;
   typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_row_type;
   typedef logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_row_type;

   // configuration
   logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_ff;
   logic [sacl_pkg::WAYS_W-1:0]       ways_ff;
   logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         ways_ff       <= sacl_pkg::WAYS_W'(1);
         block_bits_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            sacl_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_data[sacl_pkg::SET_BITS_W-1:0];
            sacl_pkg::CSR_WAYS:       ways_ff       <= csr_data[sacl_pkg::WAYS_W-1:0];
            sacl_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_data[sacl_pkg::BLOCK_BITS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   logic [3:0]              s_eff;
   logic [5:0]              ways_raw;
   logic [5:0]              ways_c;
   logic [WAY_IDX_W-1:0]    last_way;
   logic [MAX_WAYS-1:0]     in_use;

   assign s_eff    = ({1'b0, set_bits_ff} > SMAX) ? SMAX : {1'b0, set_bits_ff};
   assign ways_raw = {2'b00, ways_ff};
   assign ways_c   = (ways_raw == 6'd0) ? 6'd1 : ((ways_raw > WMAX) ? WMAX : ways_raw);
   assign last_way = WAY_IDX_W'(ways_c - 6'd1);

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (6'(w) < ways_c);
      end
   end

   // address split
   logic [ADDR_WIDTH-1:0] addr;
   logic [SHIFT_W-1:0]    shift;
   logic [ADDR_WIDTH-1:0] tag_in;
   logic [ADDR_WIDTH-1:0] set_full;
   logic [SET_IDX_W-1:0]  set_in;

   assign addr     = req_address[ADDR_WIDTH-1:0];
   assign shift    = SHIFT_W'(s_eff) + SHIFT_W'(block_bits_ff);
   assign tag_in   = addr >> shift;   // zero once offset and index cover the address
   assign set_full = addr >> block_bits_ff;
   assign set_in   = set_full[SET_IDX_W-1:0] & ~({SET_IDX_W{1'b1}} << s_eff);

   // set memories, one row per set
   valid_row_type valid_mem [NUM_SETS];
   tag_row_type   tag_mem   [NUM_SETS];
   stamp_row_type stamp_mem [NUM_SETS];

   valid_row_type        valid_rd_ff;
   tag_row_type          tag_rd_ff;
   stamp_row_type        stamp_rd_ff;
   logic [ADDR_WIDTH-1:0] tag_ff;
   logic [SET_IDX_W-1:0]  set_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         valid_rd_ff <= valid_mem[set_in];
         tag_rd_ff   <= tag_mem[set_in];
         stamp_rd_ff <= stamp_mem[set_in];
         tag_ff      <= tag_in;
         set_ff      <= set_in;
      end
   end

   // compare all ways of the set
   logic [MAX_WAYS-1:0]  match;
   logic [MAX_WAYS-1:0]  free;
   logic [WAY_IDX_W-1:0] hit_way;
   logic [WAY_IDX_W-1:0] free_way;

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         match[w] = in_use[w] && valid_rd_ff[w] && (tag_rd_ff[w] == tag_ff);
         free[w]  = in_use[w] && !valid_rd_ff[w];
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) hit_way = WAY_IDX_W'(w);   // lowest matching way wins
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (free[w]) free_way = WAY_IDX_W'(w);   // highest invalid way wins
      end
   end

   // LRU scan, one way per cycle
   logic [STAMP_WIDTH-1:0] access_ff;
   logic                   hit_ff;
   logic                   evict_ff;
   logic [WAY_IDX_W-1:0]   way_sel_ff;
   logic [WAY_IDX_W-1:0]   scan_idx_ff;
   logic [STAMP_WIDTH-1:0] best_age_ff;
   logic [STAMP_WIDTH-1:0] age;

   assign age = access_ff - stamp_rd_ff[scan_idx_ff];

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         hit_ff      <= |match;
         evict_ff    <= !(|match) && !(|free);
         way_sel_ff  <= (|match) ? hit_way : free_way;
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         if ((scan_idx_ff == '0) || (age > best_age_ff)) begin
            way_sel_ff  <= scan_idx_ff;
            best_age_ff <= age;
         end
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   // write back the chosen way
   valid_row_type valid_wr;
   tag_row_type   tag_wr;
   stamp_row_type stamp_wr;

   always_comb begin
      valid_wr             = valid_rd_ff;
      tag_wr               = tag_rd_ff;
      stamp_wr             = stamp_rd_ff;
      valid_wr[way_sel_ff] = 1'b1;
      tag_wr[way_sel_ff]   = tag_ff;
      stamp_wr[way_sel_ff] = access_ff;
   end

   logic [SET_IDX_W-1:0] clr_idx_ff;
   logic                 valid_we;
   logic [SET_IDX_W-1:0] valid_wa;
   valid_row_type        valid_wd;

   assign valid_we = cmd.clear_wr || cmd.commit;
   assign valid_wa = cmd.clear_wr ? clr_idx_ff : set_ff;
   assign valid_wd = cmd.clear_wr ? '0 : valid_wr;

   always_ff @(posedge clock) begin
      if (valid_we) valid_mem[valid_wa] <= valid_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tag_mem[set_ff]   <= tag_wr;
         stamp_mem[set_ff] <= stamp_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   // totals
   logic [sacl_pkg::TOTAL_W-1:0] hits_ff;
   logic [sacl_pkg::TOTAL_W-1:0] misses_ff;
   logic [sacl_pkg::TOTAL_W-1:0] evictions_ff;
   logic [sacl_pkg::TOTAL_W-1:0] hits_in;
   logic [sacl_pkg::TOTAL_W-1:0] misses_in;
   logic [sacl_pkg::TOTAL_W-1:0] evictions_in;

   assign hits_in      = (hit_ff && (hits_ff != '1)) ? hits_ff + 1'b1 : hits_ff;
   assign misses_in    = (!hit_ff && (misses_ff != '1)) ? misses_ff + 1'b1 : misses_ff;
   assign evictions_in = (evict_ff && (evictions_ff != '1)) ?
                         evictions_ff + 1'b1 : evictions_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         access_ff    <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evictions_ff <= '0;
      end else if (cmd.commit) begin
         access_ff    <= access_ff + 1'b1;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evictions_ff <= evictions_in;
      end
   end

   // result register
   logic                         rsp_hit_ff;
   logic                         rsp_eviction_ff;
   logic [sacl_pkg::TOTAL_W-1:0] rsp_hit_total_ff;
   logic [sacl_pkg::TOTAL_W-1:0] rsp_miss_total_ff;
   logic [sacl_pkg::TOTAL_W-1:0] rsp_eviction_total_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff            <= hit_ff;
         rsp_eviction_ff       <= evict_ff;
         rsp_hit_total_ff      <= hits_in;
         rsp_miss_total_ff     <= misses_in;
         rsp_eviction_total_ff <= evictions_in;
      end
   end

   assign rsp_hit            = rsp_hit_ff;
   assign rsp_miss           = !rsp_hit_ff;
   assign rsp_eviction       = rsp_eviction_ff;
   assign rsp_hit_total      = rsp_hit_total_ff;
   assign rsp_miss_total     = rsp_miss_total_ff;
   assign rsp_eviction_total = rsp_eviction_total_ff;

   assign status.hit        = |match;
   assign status.free_any   = |free;
   assign status.scan_last  = (scan_idx_ff == last_way);
   assign status.clear_last = (clr_idx_ff == LAST_SET);

endmodule

// ----- rtl/set_assoc_cache_lru_sim.sv -----
// Top level of the set-associative cache lookup with LRU replacement.
`timescale 1ns / 1ps

// Usage:
// - req_*: one byte address per request, taken when req_valid is high and
//   req_stall is low. The address is split into tag, set and offset using
//   the set_bits and block_bits registers; ways_in_use ways are searched.
// - rsp_*: one result per request (hit/miss/eviction flags and saturating
//   totals), taken when rsp_valid is high and rsp_stall is low.
// - csr_*: register writes (index 0 set_bits, 1 ways_in_use, 2 block_bits);
//   csr_ready is always high. Write only while no request is in flight.
// Timing: a request passes from acceptance to the result register through
// set read at acceptance, tag compare and write back. A miss with no invalid
// way adds the way-at-a-time LRU age scan over the ways in use.
// The next request is taken the cycle after write back. One request is in
// flight at a time.
// Reset: all totals and the access counter clear, and the valid bits are
// cleared one set per cycle (all 2**MAX_SET_BITS sets, 64 by default) with
// req_stall held high meanwhile. A stalled result holds in the output
// register; the next request is still taken, but its write back waits
// until the result register is free.
module set_assoc_cache_lru_sim #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64,
   parameter int STAMP_WIDTH  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sacl_pkg::ADDR_PORT_W-1:0] req_address,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic                             rsp_miss,
   output logic                             rsp_eviction,
   output logic [sacl_pkg::TOTAL_W-1:0]     rsp_hit_total,
   output logic [sacl_pkg::TOTAL_W-1:0]     rsp_miss_total,
   output logic [sacl_pkg::TOTAL_W-1:0]     rsp_eviction_total,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sacl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]  csr_data
);

   sacl_pkg::cmd_type    cmd;
   sacl_pkg::status_type status;

   assign csr_ready = 1'b1;

   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sacl_dpath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH),
      .STAMP_WIDTH  (STAMP_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_address        (req_address),
      .csr_wr             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_hit            (rsp_hit),
      .rsp_miss           (rsp_miss),
      .rsp_eviction       (rsp_eviction),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in flight");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("write back did not present a result");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_no_request_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> (req_stall && !cmd.commit))
      else $error("request activity during valid clearing pass");

endmodule

// ----- bench/cache_lookup_checker.sv -----
// Checker for the LRU cache lookup block: tracks registers, predicts every lookup, compares results.
`timescale 1ns / 1ps

module cache_lookup_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [sacl_pkg::ADDR_PORT_W-1:0] req_address,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_hit,
   input  logic                             rsp_miss,
   input  logic                             rsp_eviction,
   input  logic [sacl_pkg::TOTAL_W-1:0]     rsp_hit_total,
   input  logic [sacl_pkg::TOTAL_W-1:0]     rsp_miss_total,
   input  logic [sacl_pkg::TOTAL_W-1:0]     rsp_eviction_total,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [sacl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]  csr_data,
   output int unsigned                      mismatch_count,
   output int unsigned                      lookups_pending
);

   localparam int SET_LIMIT = 6;
   localparam int WAY_LIMIT = 8;
   localparam int LINES     = (1 << SET_LIMIT) * WAY_LIMIT;

   typedef struct packed {
      logic                         hit;
      logic                         miss;
      logic                         eviction;
      logic [sacl_pkg::TOTAL_W-1:0] hit_total;
      logic [sacl_pkg::TOTAL_W-1:0] miss_total;
      logic [sacl_pkg::TOTAL_W-1:0] eviction_total;
   } lookup_result_type;

   logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_q;
   logic [sacl_pkg::WAYS_W-1:0]       ways_q;
   logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_q;

   logic        line_valid [LINES];
   logic [63:0] line_tag   [LINES];
   logic [31:0] line_stamp [LINES];
   logic [31:0] access_count;
   logic [31:0] hits, misses, evictions;

   lookup_result_type expected_lookups [$];

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   // updates the cache image and returns the flags and totals this access gives
   function automatic lookup_result_type lookup_address(
      logic [sacl_pkg::ADDR_PORT_W-1:0] addr);
      lookup_result_type res;
      int unsigned       s, b, ways, base, slot;
      int                found, free_way, victim;
      logic [63:0]       tag;
      logic [31:0]       age, best_age;
      s    = (set_bits_q > SET_LIMIT) ? SET_LIMIT : set_bits_q;
      b    = block_bits_q;
      ways = (ways_q == 0) ? 1 : ((ways_q > WAY_LIMIT) ? WAY_LIMIT : ways_q);
      tag  = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
      base = 32'((addr >> b) & ((64'd1 << s) - 64'd1)) * WAY_LIMIT;
      found    = -1;
      free_way = -1;
      victim   = -1;
      best_age = '0;
      for (int w = 0; w < ways; w++) begin
         slot = base + w;
         if (line_valid[slot] && line_tag[slot] == tag) begin
            found = w;
            break;
         end
         if (!line_valid[slot]) begin
            free_way = w;
         end else begin
            // age is modulo the stamp width, so wrap of the counter is harmless
            age = access_count - line_stamp[slot];
            if (victim < 0 || age > best_age) begin
               victim   = w;
               best_age = age;
            end
         end
      end
      res = '0;
      if (found >= 0) begin
         res.hit = 1'b1;
         line_stamp[base + found] = access_count;
         hits = bump(hits);
      end else begin
         res.miss = 1'b1;
         if (free_way >= 0) begin
            slot = base + free_way;
         end else begin
            slot         = base + victim;
            res.eviction = 1'b1;
            evictions    = bump(evictions);
         end
         line_valid[slot] = 1'b1;
         line_tag[slot]   = tag;
         line_stamp[slot] = access_count;
         misses = bump(misses);
      end
      access_count       = access_count + 32'd1;
      res.hit_total      = hits;
      res.miss_total     = misses;
      res.eviction_total = evictions;
      return res;
   endfunction

   task automatic note_failure(string what, lookup_result_type want,
                               lookup_result_type got);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected hit=%0b miss=%0b evict=%0b totals=%0d/%0d/%0d",
                  $time, what, want.hit, want.miss, want.eviction,
                  want.hit_total, want.miss_total, want.eviction_total);
         $display("%0t %s:   actual hit=%0b miss=%0b evict=%0b totals=%0d/%0d/%0d",
                  $time, what, got.hit, got.miss, got.eviction,
                  got.hit_total, got.miss_total, got.eviction_total);
      end
   endtask

   always @(posedge clock) begin : track
      lookup_result_type want, got;
      if (reset) begin
         set_bits_q   = '0;
         ways_q       = sacl_pkg::WAYS_W'(1);
         block_bits_q = '0;
         for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
         end
         access_count = '0;
         hits         = '0;
         misses       = '0;
         evictions    = '0;
         expected_lookups.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sacl_pkg::CSR_SET_BITS:
                  set_bits_q   = csr_data[sacl_pkg::SET_BITS_W-1:0];
               sacl_pkg::CSR_WAYS:
                  ways_q       = csr_data[sacl_pkg::WAYS_W-1:0];
               sacl_pkg::CSR_BLOCK_BITS:
                  block_bits_q = csr_data[sacl_pkg::BLOCK_BITS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_lookups.push_back(lookup_address(req_address));
         end
         if (rsp_valid && !rsp_stall) begin
            got.hit            = rsp_hit;
            got.miss           = rsp_miss;
            got.eviction       = rsp_eviction;
            got.hit_total      = rsp_hit_total;
            got.miss_total     = rsp_miss_total;
            got.eviction_total = rsp_eviction_total;
            if (expected_lookups.size() == 0) begin
               note_failure("unexpected result", '0, got);
            end else begin
               want = expected_lookups.pop_front();
               if (got !== want) begin
                  note_failure("result mismatch", want, got);
               end
            end
         end
      end
      lookups_pending <= expected_lookups.size();
   end

endmodule

// ----- bench/tb_set_assoc_cache_lru_sim.sv -----
// Testbench top for the LRU cache lookup block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_sim;

   typedef logic [sacl_pkg::ADDR_PORT_W-1:0] addr_type;

   localparam logic [sacl_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned HOLD_AT     = 700;
   localparam int unsigned HOLD_CYCLES = 300;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   addr_type                         req_address;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_hit;
   logic                             rsp_miss;
   logic                             rsp_eviction;
   logic [sacl_pkg::TOTAL_W-1:0]     rsp_hit_total;
   logic [sacl_pkg::TOTAL_W-1:0]     rsp_miss_total;
   logic [sacl_pkg::TOTAL_W-1:0]     rsp_eviction_total;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [sacl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sacl_pkg::CSR_DATA_W-1:0]  csr_data;

   int unsigned mismatch_count;
   int unsigned lookups_pending;
   int unsigned requests_sent;
   bit          steady;

   // effective split and way count, used only to shape addresses
   int unsigned cfg_set_bits;
   int unsigned cfg_ways;
   int unsigned cfg_block_bits;

   set_assoc_cache_lru_sim u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_miss           (rsp_miss),
      .rsp_eviction       (rsp_eviction),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   cache_lookup_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_miss           (rsp_miss),
      .rsp_eviction       (rsp_eviction),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .lookups_pending    (lookups_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic addr_type rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic addr_type build_address(addr_type tag, int unsigned set,
                                              addr_type offset);
      int unsigned split;
      addr_type    a;
      split = cfg_set_bits + cfg_block_bits;
      a = (split >= sacl_pkg::ADDR_PORT_W) ? '0 : (tag << split);
      a |= (addr_type'(set) & ((addr_type'(1) << cfg_set_bits) - 1)) << cfg_block_bits;
      a |= offset & ((addr_type'(1) << cfg_block_bits) - 1);
      return a;
   endfunction

   // leaves csr_valid high; configure lowers it after the last write
   task automatic write_reg(input logic [sacl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sacl_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [sacl_pkg::CSR_DATA_W-1:0] sb,
                            input logic [sacl_pkg::CSR_DATA_W-1:0] wy,
                            input logic [sacl_pkg::CSR_DATA_W-1:0] bb);
      write_reg(sacl_pkg::CSR_SET_BITS, sb);
      write_reg(sacl_pkg::CSR_WAYS, wy);
      write_reg(sacl_pkg::CSR_BLOCK_BITS, bb);
      csr_valid <= 1'b0;
      cfg_set_bits   = (sb[2:0] > 6) ? 6 : sb[2:0];
      cfg_ways       = (wy[3:0] == 0) ? 1 : ((wy[3:0] > 8) ? 8 : wy[3:0]);
      cfg_block_bits = bb;
   endtask

   // request stays valid after acceptance so back-to-back requests need no toggle
   task automatic send_request(input addr_type addr);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lookups_pending != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned count);
      addr_type    tag_pool [$];
      int unsigned set_pool [4];
      int unsigned pool_size;
      addr_type    addr;
      logic [sacl_pkg::CSR_DATA_W-1:0] bb;
      bb = ($urandom_range(0, 99) < 70) ? sacl_pkg::CSR_DATA_W'($urandom_range(0, 12))
                                        : sacl_pkg::CSR_DATA_W'($urandom_range(0, 63));
      configure(sacl_pkg::CSR_DATA_W'($urandom), sacl_pkg::CSR_DATA_W'($urandom), bb);
      steady    = ($urandom_range(0, 3) == 0);
      pool_size = cfg_ways + $urandom_range(0, 3);
      for (int i = 0; i < pool_size; i++) begin
         tag_pool.push_back(rand_word());
      end
      foreach (set_pool[k]) set_pool[k] = $urandom;
      // mostly a small working set so hits and evictions are frequent
      repeat (count) begin
         if ($urandom_range(0, 99) < 85) begin
            addr = build_address(tag_pool[$urandom_range(0, pool_size - 1)],
                                 set_pool[$urandom_range(0, 3)], rand_word());
         end else begin
            addr = rand_word();
         end
         send_request(addr);
      end
      drain();
      steady = 1'b0;
   endtask

   initial begin : rsp_backpressure
      int unsigned hold_len;
      int unsigned open_len;
      bit          held_off;
      held_off = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && requests_sent >= HOLD_AT) begin
            held_off = 1'b1;
            hold_len = HOLD_CYCLES;
         end else begin
            hold_len = steady ? 0 : pick_gap();
         end
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         open_len = steady ? 0 : $urandom_range(0, 4);
         repeat (open_len) @(posedge clock);
      end
   end

   initial begin : stimulus
      req_valid   <= 1'b0;
      req_address <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= sacl_pkg::CSR_SET_BITS;
      csr_data    <= '0;
      reset       <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // valid bits are cleared set by set after reset
      while (req_stall) @(posedge clock);

      // direct mapped, one set: hit and eviction on the two extreme addresses
      configure(6'd0, 6'd1, 6'd0);
      send_request('0);
      send_request('0);
      send_request('1);
      send_request('1);
      send_request('0);
      drain();

      // set_bits 7 clamps to 6, ways 0 acts as 1, offset covers all but the top bit
      write_reg(CSR_UNUSED, 6'h2A);
      configure(6'h3F, 6'h30, 6'h3F);
      send_request('0);
      send_request(64'h8000_0000_0000_0000);
      send_request('1);
      send_request(64'h7FFF_FFFF_FFFF_FFFF);
      drain();

      // offset plus index exactly cover the address, tag is zero
      configure(6'd6, 6'd8, 6'd58);
      send_request(64'hFC00_0000_0000_0000);
      send_request('1);
      send_request('0);
      drain();

      // ways above the limit clamp to 8: fill a set, refresh one, evict the oldest twice
      configure(6'b001010, 6'b001111, 6'd4);
      for (int t = 1; t <= 8; t++) begin
         send_request(build_address(addr_type'(t), 0, '0));
      end
      send_request(build_address(addr_type'(1), 0, '0));
      send_request(build_address(addr_type'(9), 0, '0));
      send_request(build_address(addr_type'(2), 0, '0));
      drain();

      repeat (12) random_phase(125);

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && lookups_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
